/* rtl/mhp_pkg.sv */
// Shared constants, types and field-layout functions for the 802.15.4 MAC header parser.
package mhp_pkg;

  // Frame length limits.
  localparam int MAX_FRAME_BYTES = 127;
  localparam int MIN_FRAME_BYTES = 11;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

  // Header layout widths: offsets and the end mark fit below 32, lengths below 16.
  localparam int LAY_W = 5;
  localparam int LEN_W = 4;

  localparam logic [LAY_W-1:0] FIRST_ADDR_OFFSET = LAY_W'(3);
  localparam logic [LEN_W-1:0] LONG_ADDR_BYTES   = LEN_W'(8);
  localparam logic [LEN_W-1:0] SHORT_ADDR_BYTES  = LEN_W'(2);
  localparam logic [LEN_W-1:0] PAN_ID_BYTES      = LEN_W'(2);

  // Byte positions of the fixed header fields.
  localparam logic [POS_W-1:0] POS_FC_LOW  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FC_HIGH = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SEQ     = POS_W'(2);

  // Addressing mode code for a long (extended) address.
  localparam logic [1:0] ADDR_MODE_LONG = 2'd3;

  // Frame type codes.
  localparam logic [2:0] FT_BEACON  = 3'd0;
  localparam logic [2:0] FT_DATA    = 3'd1;
  localparam logic [2:0] FT_ACK     = 3'd2;
  localparam logic [2:0] FT_COMMAND = 3'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  // Where each addressing field sits in the frame; a zero length means absent.
  typedef struct packed {
    logic [LAY_W-1:0] dp_off;
    logic [LEN_W-1:0] dp_len;
    logic [LAY_W-1:0] da_off;
    logic [LEN_W-1:0] da_len;
    logic [LAY_W-1:0] sp_off;
    logic [LEN_W-1:0] sp_len;
    logic [LAY_W-1:0] sa_off;
    logic [LEN_W-1:0] sa_len;
    logic [LAY_W-1:0] end_pos;
  } layout_t;

  // Address length in bytes for an addressing mode.
  function automatic logic [LEN_W-1:0] addr_len(logic [1:0] mode);
    return (mode == ADDR_MODE_LONG) ? LONG_ADDR_BYTES : SHORT_ADDR_BYTES;
  endfunction

  // Derive the addressing field layout from the frame control word.
  function automatic layout_t make_layout(logic [15:0] fc);
    layout_t          l;
    logic [LAY_W-1:0] pos;
    l   = '0;
    pos = FIRST_ADDR_OFFSET;
    case (fc[2:0]) inside
      FT_BEACON: begin
        l.sp_off = pos;
        l.sp_len = PAN_ID_BYTES;
        pos      = pos + LAY_W'(PAN_ID_BYTES);
        l.sa_off = pos;
        l.sa_len = addr_len(fc[15:14]);
        pos      = pos + LAY_W'(l.sa_len);
      end
      FT_DATA, FT_COMMAND: begin
        l.dp_off = pos;
        l.dp_len = PAN_ID_BYTES;
        pos      = pos + LAY_W'(PAN_ID_BYTES);
        l.da_off = pos;
        l.da_len = addr_len(fc[11:10]);
        pos      = pos + LAY_W'(l.da_len);
        // Intra-PAN frames omit the source PAN id.
        if (!fc[6]) begin
          l.sp_off = pos;
          l.sp_len = PAN_ID_BYTES;
          pos      = pos + LAY_W'(PAN_ID_BYTES);
        end
        l.sa_off = pos;
        l.sa_len = addr_len(fc[15:14]);
        pos      = pos + LAY_W'(l.sa_len);
      end
      default: begin
      end
    endcase
    l.end_pos = pos;
    return l;
  endfunction

  // Drop byte b into its little-endian lane when position p lies inside the field.
  function automatic logic [63:0] put_byte(logic [63:0] fld, logic [POS_W-1:0] p,
                                           logic [LAY_W-1:0] off, logic [LEN_W-1:0] len,
                                           logic [7:0] b);
    logic [63:0] r;
    r = fld;
    for (int k = 0; k < 8; k++) begin
      if ((LEN_W'(k) < len) && (p == POS_W'(off) + POS_W'(k))) begin
        r[8*k +: 8] = b;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/mhp_if.sv */
// Valid/ready channel interfaces for the frame byte input and the header result output.
interface mhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface mhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] frame_control;
  logic [2:0]  frame_type;
  logic [7:0]  seq_number;
  logic [15:0] dst_pan;
  logic [63:0] dst_address;
  logic [15:0] src_pan;
  logic [63:0] src_address;

  modport source (output valid, output status, output frame_control, output frame_type,
                  output seq_number, output dst_pan, output dst_address,
                  output src_pan, output src_address, input ready);
  modport sink   (input valid, input status, input frame_control, input frame_type,
                  input seq_number, input dst_pan, input dst_address,
                  input src_pan, input src_address, output ready);
endinterface

/* rtl/ieee802154_mac_header_parser_top.sv */
// Top level of the 802.15.4 MAC header parser: byte-wise field capture and result register.
// Throughput: one frame byte per cycle, sustained while results are taken as they appear.
// Latency: the result appears in the cycle after the last byte's transaction.
// Rate is set by the single capture stage feeding the one-deep result register;
// a new byte is taken whenever that register is empty or being drained.
// Reset (rst, synchronous) clears the frame state and empties the result register.
module ieee802154_mac_header_parser_top (
  input logic       clk,
  input logic       rst,
  mhp_in_if.sink    frame_bytes,
  mhp_out_if.source header
);
  import mhp_pkg::*;

  // Frame state.
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      control_word, control_word_next;
  logic [7:0]       sequence_byte, sequence_byte_next;
  logic [15:0]      dst_pan_reg, dst_pan_reg_next;
  logic [63:0]      dst_address_reg, dst_address_reg_next;
  logic [15:0]      src_pan_reg, src_pan_reg_next;
  logic [63:0]      src_address_reg, src_address_reg_next;

  // Result register.
  logic        out_valid;
  logic [1:0]  status, status_next;
  logic [15:0] frame_control, frame_control_next;
  logic [7:0]  seq_number, seq_number_next;
  logic [15:0] dst_pan, dst_pan_next;
  logic [63:0] dst_address, dst_address_next;
  logic [15:0] src_pan, src_pan_next;
  logic [63:0] src_address, src_address_next;

  logic    accept;
  layout_t cap_layout;
  layout_t end_layout;
  logic    in_range;
  logic [63:0] dp_wide, sp_wide;

  // Take a byte whenever the result register can hold a new result.
  assign frame_bytes.ready = !out_valid || header.ready;
  assign accept            = frame_bytes.valid && frame_bytes.ready;

  // Field capture at the current byte position.
  always_comb begin
    cap_layout = make_layout(control_word);
    in_range   = byte_position < POS_W'(MAX_FRAME_BYTES);

    byte_position_next   = byte_position;
    control_word_next    = control_word;
    sequence_byte_next   = sequence_byte;
    dst_pan_reg_next     = dst_pan_reg;
    dst_address_reg_next = dst_address_reg;
    src_pan_reg_next     = src_pan_reg;
    src_address_reg_next = src_address_reg;

    dp_wide = put_byte({48'd0, dst_pan_reg}, byte_position, cap_layout.dp_off,
                       cap_layout.dp_len, frame_bytes.frame_byte);
    sp_wide = put_byte({48'd0, src_pan_reg}, byte_position, cap_layout.sp_off,
                       cap_layout.sp_len, frame_bytes.frame_byte);

    if (in_range) begin
      if (byte_position == POS_FC_LOW) begin
        control_word_next[7:0] = frame_bytes.frame_byte;
      end else if (byte_position == POS_FC_HIGH) begin
        control_word_next[15:8] = frame_bytes.frame_byte;
      end else if (byte_position == POS_SEQ) begin
        sequence_byte_next = frame_bytes.frame_byte;
      end else begin
        dst_pan_reg_next     = dp_wide[15:0];
        dst_address_reg_next = put_byte(dst_address_reg, byte_position, cap_layout.da_off,
                                        cap_layout.da_len, frame_bytes.frame_byte);
        src_pan_reg_next     = sp_wide[15:0];
        src_address_reg_next = put_byte(src_address_reg, byte_position, cap_layout.sa_off,
                                        cap_layout.sa_len, frame_bytes.frame_byte);
      end
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  // Result built from the state as it stands after this byte.
  always_comb begin
    end_layout         = make_layout(control_word_next);
    status_next        = STATUS_OK;
    frame_control_next = '0;
    seq_number_next    = '0;
    dst_pan_next       = '0;
    dst_address_next   = '0;
    src_pan_next       = '0;
    src_address_next   = '0;
    if (byte_position_next < POS_W'(MIN_FRAME_BYTES)) begin
      status_next = STATUS_SHORT;
    end else begin
      frame_control_next = control_word_next;
      seq_number_next    = sequence_byte_next;
      if (byte_position_next < POS_W'(end_layout.end_pos)) begin
        status_next = STATUS_TRUNC;
      end else begin
        dst_pan_next     = dst_pan_reg_next;
        dst_address_next = dst_address_reg_next;
        src_pan_next     = src_pan_reg_next;
        src_address_next = src_address_reg_next;
      end
    end
  end

  // Frame state: advance on each byte, clear after the last one.
  always_ff @(posedge clk) begin
    if (rst || (accept && frame_bytes.last_byte)) begin
      byte_position   <= '0;
      control_word    <= '0;
      sequence_byte   <= '0;
      dst_pan_reg     <= '0;
      dst_address_reg <= '0;
      src_pan_reg     <= '0;
      src_address_reg <= '0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      control_word    <= control_word_next;
      sequence_byte   <= sequence_byte_next;
      dst_pan_reg     <= dst_pan_reg_next;
      dst_address_reg <= dst_address_reg_next;
      src_pan_reg     <= src_pan_reg_next;
      src_address_reg <= src_address_reg_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && frame_bytes.last_byte) begin
      out_valid <= 1'b1;
    end else if (header.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept && frame_bytes.last_byte) begin
      status        <= status_next;
      frame_control <= frame_control_next;
      seq_number    <= seq_number_next;
      dst_pan       <= dst_pan_next;
      dst_address   <= dst_address_next;
      src_pan       <= src_pan_next;
      src_address   <= src_address_next;
    end
  end

  assign header.valid         = out_valid;
  assign header.status        = status;
  assign header.frame_control = frame_control;
  assign header.frame_type    = frame_control[2:0];
  assign header.seq_number    = seq_number;
  assign header.dst_pan       = dst_pan;
  assign header.dst_address   = dst_address;
  assign header.src_pan       = src_pan;
  assign header.src_address   = src_address;

endmodule

/* rtl/mhp_checker.sv */
// Port-level checks for the 802.15.4 MAC header parser, bound to its top level.
module mhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_frame_control,
  input logic [2:0]  out_frame_type,
  input logic [63:0] out_dst_address,
  input logic [63:0] out_src_address
);
  import mhp_pkg::*;

  // A stalled result keeps its status.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  // With no result pending, the input side must be open.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while result register is empty");

  // A new result only follows a last-byte transaction.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
    else $error("result without a last byte");

  // A short frame reports nothing but its status.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == STATUS_SHORT) |->
      (out_frame_control == 16'd0) && (out_dst_address == 64'd0) &&
      (out_src_address == 64'd0))
    else $error("short frame result carries fields");

  // The frame type always matches the low bits of the frame control word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_frame_type == out_frame_control[2:0]))
    else $error("frame type disagrees with frame control");

endmodule

bind ieee802154_mac_header_parser_top mhp_checker u_mhp_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (frame_bytes.valid),
  .in_ready         (frame_bytes.ready),
  .in_last          (frame_bytes.last_byte),
  .out_valid        (header.valid),
  .out_ready        (header.ready),
  .out_status       (header.status),
  .out_frame_control(header.frame_control),
  .out_frame_type   (header.frame_type),
  .out_dst_address  (header.dst_address),
  .out_src_address  (header.src_address)
);

/* dv/tb_top.sv */
// Self-checking testbench for the 802.15.4 MAC header parser: frame stimulus, header prediction.
`timescale 1ns / 100ps

module tb_top;
  import mhp_pkg::*;

  localparam int  CLK_HALF_NS   = 10;
  localparam int  RESET_CYCLES  = 8;
  localparam int  RANDOM_BYTES  = 1500;
  localparam int  DRAIN_CYCLES  = 8;
  localparam int  HOLD_START    = 1000;
  localparam int  HOLD_CYCLES   = 500;
  localparam int  MAX_SHOWN     = 10;
  localparam longint TIMEOUT_NS = 10_000_000;

  // One parsed header, laid out as the result channel carries it.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] frame_control;
    logic [2:0]  frame_type;
    logic [7:0]  seq_number;
    logic [15:0] dst_pan;
    logic [63:0] dst_address;
    logic [15:0] src_pan;
    logic [63:0] src_address;
  } header_t;

  // Byte offsets and lengths of the addressing fields; a zero length means absent.
  typedef struct packed {
    int dp_at;
    int dp_n;
    int da_at;
    int da_n;
    int sp_at;
    int sp_n;
    int sa_at;
    int sa_n;
    int hdr_end;
  } addr_map_t;

  // One directed frame: header bytes, length, payload fill and an optional fixed status.
  typedef struct packed {
    logic [15:0] fc;
    logic [7:0]  seq;
    int          n;
    logic [7:0]  fill;
    bit          typed;
    logic [1:0]  status;
  } frame_row_t;

  localparam int N_DIRECTED = 16;

  frame_row_t directed_frames [N_DIRECTED] = '{
    //  fc        seq    bytes fill   typed  status
    '{16'h00FF, 8'h00, 1,    8'h00, 1'b1, STATUS_SHORT},  // single byte frame
    '{16'h8841, 8'h11, 10,   8'h00, 1'b1, STATUS_SHORT},  // one byte under minimum
    '{16'h0002, 8'h5A, 11,   8'h00, 1'b1, STATUS_OK},     // ack, no addressing
    '{16'hFFFF, 8'hFF, 11,   8'hFF, 1'b1, STATUS_OK},     // reserved type, all ones
    '{16'h8000, 8'h01, 11,   8'h10, 1'b0, STATUS_OK},     // beacon, short source
    '{16'hC000, 8'h02, 13,   8'hF4, 1'b0, STATUS_OK},     // beacon, long source
    '{16'hCC01, 8'h03, 23,   8'h00, 1'b0, STATUS_OK},     // data, long/long with source PAN
    '{16'h8841, 8'h04, 11,   8'h20, 1'b0, STATUS_OK},     // data, intra-PAN short/short
    '{16'hCC43, 8'h05, 20,   8'h40, 1'b1, STATUS_TRUNC},  // command, one byte short
    '{16'hCC01, 8'h06, 22,   8'h60, 1'b1, STATUS_TRUNC},  // data, one byte short
    '{16'hCC01, 8'h07, 140,  8'h80, 1'b0, STATUS_OK},     // overlong frame
    '{16'h8801, 8'h08, 30,   8'h33, 1'b0, STATUS_OK},     // trailing payload bytes
    '{16'h4C01, 8'h09, 17,   8'hC0, 1'b0, STATUS_OK},     // long dest, mode 1 source
    '{16'h8803, 8'h0A, 11,   8'h55, 1'b0, STATUS_OK},     // command, short/short
    '{16'hC000, 8'h0B, 12,   8'hA0, 1'b1, STATUS_TRUNC},  // beacon, one byte short
    '{16'h0004, 8'h0C, 10,   8'h00, 1'b1, STATUS_SHORT}   // reserved type, too short
  };

  logic clk;
  logic rst;

  mhp_in_if  frame_bytes_if ();
  mhp_out_if header_if ();

  ieee802154_mac_header_parser_top u_top (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes_if),
    .header      (header_if)
  );

  // Predictor state for the frame in progress.
  logic [6:0]  pos_q;
  logic [15:0] fc_q;
  logic [7:0]  seq_q;
  logic [15:0] dpan_q;
  logic [63:0] daddr_q;
  logic [15:0] span_q;
  logic [63:0] saddr_q;

  header_t pending_headers [$];
  int      fail_count;
  int      shown_count;
  int      bytes_sent;
  int      burst_left;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // Work out where the addressing fields sit for a frame control word.
  function automatic addr_map_t map_fields(logic [15:0] fc);
    addr_map_t m;
    int        at;
    m  = '0;
    at = 3;
    if (fc[2:0] == FT_BEACON) begin
      m.sp_at = at;
      m.sp_n  = 2;
      at      = at + 2;
      m.sa_at = at;
      m.sa_n  = (fc[15:14] == ADDR_MODE_LONG) ? 8 : 2;
      at      = at + m.sa_n;
    end else if (fc[2:0] == FT_DATA || fc[2:0] == FT_COMMAND) begin
      m.dp_at = at;
      m.dp_n  = 2;
      at      = at + 2;
      m.da_at = at;
      m.da_n  = (fc[11:10] == ADDR_MODE_LONG) ? 8 : 2;
      at      = at + m.da_n;
      // The source PAN id is only present when intra-PAN is clear.
      if (!fc[6]) begin
        m.sp_at = at;
        m.sp_n  = 2;
        at      = at + 2;
      end
      m.sa_at = at;
      m.sa_n  = (fc[15:14] == ADDR_MODE_LONG) ? 8 : 2;
      at      = at + m.sa_n;
    end
    m.hdr_end = at;
    return m;
  endfunction

  // Drop a byte into its little-endian lane when the position falls inside the field.
  function automatic logic [63:0] place_byte(logic [63:0] fld, int p, int at, int n,
                                             logic [7:0] b);
    if (n != 0 && p >= at && p < at + n) begin
      fld[8*(p-at) +: 8] = b;
    end
    return fld;
  endfunction

  // Advance the predicted frame state by one byte; on the last byte produce the header.
  task automatic predict_header(input logic [7:0] b, input logic fin,
                                output bit done, output header_t h);
    addr_map_t   m;
    logic [63:0] wide;
    int          p;
    p    = pos_q;
    done = 1'b0;
    h    = '0;
    if (p < MAX_FRAME_BYTES) begin
      case (p)
        POS_FC_LOW:  fc_q[7:0]  = b;
        POS_FC_HIGH: fc_q[15:8] = b;
        POS_SEQ:     seq_q      = b;
        default: begin
          m       = map_fields(fc_q);
          wide    = place_byte({48'd0, dpan_q}, p, m.dp_at, m.dp_n, b);
          dpan_q  = wide[15:0];
          daddr_q = place_byte(daddr_q, p, m.da_at, m.da_n, b);
          wide    = place_byte({48'd0, span_q}, p, m.sp_at, m.sp_n, b);
          span_q  = wide[15:0];
          saddr_q = place_byte(saddr_q, p, m.sa_at, m.sa_n, b);
        end
      endcase
      pos_q = pos_q + 7'd1;
    end
    if (fin) begin
      done = 1'b1;
      m    = map_fields(fc_q);
      if (pos_q < MIN_FRAME_BYTES) begin
        h.status = STATUS_SHORT;
      end else begin
        h.frame_control = fc_q;
        h.frame_type    = fc_q[2:0];
        h.seq_number    = seq_q;
        if (pos_q < m.hdr_end) begin
          h.status = STATUS_TRUNC;
        end else begin
          h.status      = STATUS_OK;
          h.dst_pan     = dpan_q;
          h.dst_address = daddr_q;
          h.src_pan     = span_q;
          h.src_address = saddr_q;
        end
      end
      pos_q   = '0;
      fc_q    = '0;
      seq_q   = '0;
      dpan_q  = '0;
      daddr_q = '0;
      span_q  = '0;
      saddr_q = '0;
    end
  endtask

  // Offer one byte, idling between bursts, and record the expected header on acceptance.
  task automatic send_byte(input logic [7:0] b, input logic fin,
                           input bit typed, input header_t typed_hdr);
    int      gap;
    bit      took;
    bit      done;
    header_t h;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        frame_bytes_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    frame_bytes_if.valid      <= 1'b1;
    frame_bytes_if.frame_byte <= b;
    frame_bytes_if.last_byte  <= fin;
    // The transaction completes at the next rising edge where ready was seen high.
    do begin
      @(negedge clk);
      took = frame_bytes_if.ready;
      @(posedge clk);
    end while (!took);
    predict_header(b, fin, done, h);
    if (done) begin
      pending_headers.push_back(typed ? typed_hdr : h);
    end
    bytes_sent = bytes_sent + 1;
  endtask

  // Send a whole frame: control word, sequence number, then fill or random content.
  task automatic send_frame(input logic [15:0] fc, input logic [7:0] seq, input int n,
                            input logic [7:0] fill, input bit rand_body,
                            input bit typed, input header_t typed_hdr);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      if (k == 0) begin
        b = fc[7:0];
      end else if (k == 1) begin
        b = fc[15:8];
      end else if (k == 2) begin
        b = seq;
      end else begin
        b = rand_body ? 8'($urandom_range(0, 255)) : fill + k[7:0];
      end
      send_byte(b, k == n - 1, typed, typed_hdr);
    end
  endtask

  // Mostly well-formed frames with random content, plus short, cut and overlong ones.
  task automatic send_random_frame();
    logic [15:0] fc;
    addr_map_t   m;
    int          full;
    int          shape;
    int          n;
    fc = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < 80) begin
      case ($urandom_range(0, 2))
        0:       fc[2:0] = FT_BEACON;
        1:       fc[2:0] = FT_DATA;
        default: fc[2:0] = FT_COMMAND;
      endcase
    end
    m     = map_fields(fc);
    full  = (m.hdr_end > MIN_FRAME_BYTES) ? m.hdr_end : MIN_FRAME_BYTES;
    shape = $urandom_range(0, 99);
    if (shape < 70) begin
      n = full + $urandom_range(0, 6);
    end else if (shape < 82 && m.hdr_end > MIN_FRAME_BYTES) begin
      n = $urandom_range(MIN_FRAME_BYTES, m.hdr_end - 1);
    end else if (shape < 92) begin
      n = $urandom_range(1, MIN_FRAME_BYTES - 1);
    end else if (shape < 96) begin
      n = $urandom_range(MAX_FRAME_BYTES - 7, MAX_FRAME_BYTES + 13);
    end else begin
      n = full;
    end
    send_frame(fc, 8'($urandom_range(0, 255)), n, 8'd0, 1'b1, 1'b0, '0);
  endtask

  // Compare one accepted header against the oldest expectation.
  task automatic check_header(input header_t got);
    header_t want;
    if (pending_headers.size() == 0) begin
      fail_count = fail_count + 1;
      if (shown_count < MAX_SHOWN) begin
        shown_count = shown_count + 1;
        $display("unexpected header at %0t: st=%0d fc=%h", $time, got.status,
                 got.frame_control);
      end
    end else begin
      want = pending_headers.pop_front();
      if (got !== want) begin
        fail_count = fail_count + 1;
        if (shown_count < MAX_SHOWN) begin
          shown_count = shown_count + 1;
          $display("header mismatch at %0t", $time);
          $display("  want st=%0d fc=%h ty=%0d seq=%h dp=%h da=%h sp=%h sa=%h",
                   want.status, want.frame_control, want.frame_type, want.seq_number,
                   want.dst_pan, want.dst_address, want.src_pan, want.src_address);
          $display("  got  st=%0d fc=%h ty=%0d seq=%h dp=%h da=%h sp=%h sa=%h",
                   got.status, got.frame_control, got.frame_type, got.seq_number,
                   got.dst_pan, got.dst_address, got.src_pan, got.src_address);
        end
      end
    end
  endtask

  // Result monitor: a transaction completes at the edge after valid and ready are seen high.
  initial begin
    header_t got;
    forever begin
      @(negedge clk);
      if (!rst && header_if.valid && header_if.ready) begin
        got.status        = header_if.status;
        got.frame_control = header_if.frame_control;
        got.frame_type    = header_if.frame_type;
        got.seq_number    = header_if.seq_number;
        got.dst_pan       = header_if.dst_pan;
        got.dst_address   = header_if.dst_address;
        got.src_pan       = header_if.src_pan;
        got.src_address   = header_if.src_address;
        check_header(got);
      end
    end
  end

  // Receiver: changing stall patterns, with one long hold-off to back up the input.
  initial begin
    int cyc;
    int seg_left;
    int mode;
    header_if.ready <= 1'b0;
    cyc      = 0;
    seg_left = 0;
    mode     = 0;
    forever begin
      @(posedge clk);
      cyc = cyc + 1;
      if (seg_left == 0) begin
        seg_left = $urandom_range(50, 300);
        mode     = $urandom_range(0, 3);
      end
      seg_left = seg_left - 1;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
        header_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       header_if.ready <= 1'b1;
          1:       header_if.ready <= ($urandom_range(0, 3) != 0);
          2:       header_if.ready <= ($urandom_range(0, 3) == 0);
          default: header_if.ready <= ((cyc % 7) < 4);
        endcase
      end
    end
  end

  // Reset, directed frames, random frames, then drain and report.
  initial begin
    header_t typed_hdr;
    frame_row_t row;
    rst                       <= 1'b1;
    frame_bytes_if.valid      <= 1'b0;
    frame_bytes_if.frame_byte <= '0;
    frame_bytes_if.last_byte  <= 1'b0;
    pos_q       = '0;
    fc_q        = '0;
    seq_q       = '0;
    dpan_q      = '0;
    daddr_q     = '0;
    span_q      = '0;
    saddr_q     = '0;
    fail_count  = 0;
    shown_count = 0;
    bytes_sent  = 0;
    burst_left  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed frames; typed rows carry a status whose header is obvious from the row.
    for (int i = 0; i < N_DIRECTED; i++) begin
      row       = directed_frames[i];
      typed_hdr = '0;
      if (row.typed) begin
        typed_hdr.status = row.status;
        if (row.status != STATUS_SHORT) begin
          typed_hdr.frame_control = row.fc;
          typed_hdr.frame_type    = row.fc[2:0];
          typed_hdr.seq_number    = row.seq;
        end
      end
      send_frame(row.fc, row.seq, row.n, row.fill, 1'b0, row.typed, typed_hdr);
    end

    // Random frames until the total byte count is reached.
    while (bytes_sent < RANDOM_BYTES) begin
      send_random_frame();
    end
    frame_bytes_if.valid <= 1'b0;

    while (pending_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mhp_pkg.sv
rtl/mhp_if.sv
rtl/ieee802154_mac_header_parser_top.sv
rtl/mhp_checker.sv
dv/tb_top.sv
